FILE: hw/rtl/tsls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer size loop splitter package
// Widths, register indexes and the word types shared by the pipeline stages.
// ----------------------------------------------------------------------------
package tsls_pkg;

   localparam int ITER_FIELD_BITS = 13;
   localparam int SIZE_W          = 53;
   localparam int LC_W            = 8;
   localparam int SB_W            = 32;
   localparam int N_BITS          = 7;
   localparam int LOOP_W          = LC_W + SB_W;
   localparam int MAXSZ_W         = LOOP_W + ITER_FIELD_BITS;
   localparam int CMP_W           = ((MAXSZ_W > SIZE_W) ? MAXSZ_W : SIZE_W) + 1;
   localparam int DIV_STAGES      = ITER_FIELD_BITS + N_BITS;

   localparam int ITER_OUT_W      = 13;
   localparam int EXT_W           = 62;
   localparam int TAIL_W          = 32;
   localparam int PAR_W           = 8;
   localparam int REPEAT_SHIFT    = 55;
   localparam int LOOPIDX_SHIFT   = 48;
   localparam int TOTAL_SHIFT     = 41;

   localparam int REQ_DATA_W      = 56;
   localparam int RSP_DATA_W      = 168;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SBYTES = CSR_IDX_W'(1);

   localparam logic [LC_W-1:0]            SLICES_MAX = LC_W'(128);
   localparam logic [ITER_FIELD_BITS-1:0] MAX_ITER   = '1;

   typedef struct packed {
      logic [SIZE_W-1:0]          size;
      logic [LC_W-1:0]            lc;
      logic [SB_W-1:0]            sb;
      logic [LOOP_W-1:0]          loop_size;
      logic                       is_max;
      logic                       ovf;
      logic [SIZE_W-1:0]          rem;
      logic [SIZE_W-1:0]          offset;
      logic [ITER_FIELD_BITS-1:0] m;
      logic [N_BITS-1:0]          n;
   } item_type;

   typedef struct packed {
      logic                  size_overflow;
      logic [TAIL_W-1:0]     tail_bytes;
      logic [EXT_W-1:0]      extend_word;
      logic [ITER_OUT_W-1:0] iteration_count;
      logic [SIZE_W-1:0]     group_offset;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/tsls_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer size loop splitter front end
// Clamps the configuration, forms the loop size and saturates the size.
// ----------------------------------------------------------------------------
module tsls_prep (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           in_valid,
   output logic                          in_ready,
   input  wire  [tsls_pkg::SIZE_W-1:0]   in_size,
   input  wire  [tsls_pkg::LC_W-1:0]     cfg_slices,
   input  wire  [tsls_pkg::SB_W-1:0]     cfg_sbytes,
   output logic                          out_valid,
   input  wire                           out_ready,
   output tsls_pkg::item_type            out_item
);
   import tsls_pkg::*;

   item_type   st_ff [3];
   item_type   st_in [3];
   logic [2:0] vld_ff;
   logic [3:0] rdy;
   logic [CMP_W-1:0] max_size;
   logic [CMP_W-1:0] size_c;

   assign rdy[3] = out_ready;
   assign rdy[2] = !vld_ff[2] || rdy[3];
   assign rdy[1] = !vld_ff[1] || rdy[2];
   assign rdy[0] = !vld_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[2];
   assign out_item  = st_ff[2];

   always_comb begin
      st_in[0]      = '0;
      st_in[0].size = in_size;
      st_in[0].lc   = (cfg_slices == '0) ? LC_W'(1) :
                      ((cfg_slices > SLICES_MAX) ? SLICES_MAX : cfg_slices);
      st_in[0].sb   = (cfg_sbytes == '0) ? SB_W'(1) : cfg_sbytes;

      st_in[1]           = st_ff[0];
      st_in[1].loop_size = LOOP_W'(st_ff[0].lc) * LOOP_W'(st_ff[0].sb);

      // Sizes at or above the maximum take the saturated encoding.
      max_size        = CMP_W'(st_ff[1].loop_size) << ITER_FIELD_BITS;
      size_c          = CMP_W'(st_ff[1].size);
      st_in[2]        = st_ff[1];
      st_in[2].is_max = (size_c >= max_size);
      st_in[2].ovf    = (size_c > max_size);
      if (size_c >= max_size) begin
         st_in[2].size = SIZE_W'(max_size);
      end
      st_in[2].rem = st_in[2].size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) st_ff[0] <= st_in[0];
      if (rdy[1]) st_ff[1] <= st_in[1];
      if (rdy[2]) st_ff[2] <= st_in[2];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tsls_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer size loop splitter divider
// Restoring division, one quotient bit per stage: groups first, then slices.
// ----------------------------------------------------------------------------
module tsls_div (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  tsls_pkg::item_type  in_item,
   output logic                out_valid,
   input  wire                 out_ready,
   output tsls_pkg::item_type  out_item
);
   import tsls_pkg::*;

   item_type                st_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0]   vld_ff;
   logic [DIV_STAGES:0]     rdy;

   function automatic item_type div_step(input item_type x, input int i);
      item_type         y;
      logic [CMP_W-1:0] dv;
      logic [CMP_W-1:0] trial;
      logic             borrow;
      y = x;
      if (i < ITER_FIELD_BITS) begin
         dv = CMP_W'(x.loop_size) << (ITER_FIELD_BITS - 1 - i);
      end else begin
         dv = CMP_W'(x.sb) << (N_BITS - 1 - (i - ITER_FIELD_BITS));
      end
      trial  = CMP_W'(x.rem) - dv;
      borrow = trial[CMP_W-1];
      if (!borrow) y.rem = SIZE_W'(trial);
      if (i < ITER_FIELD_BITS) begin
         y.m = {x.m[ITER_FIELD_BITS-2:0], !borrow};
      end else begin
         y.n = {x.n[N_BITS-2:0], !borrow};
      end
      // The remainder left by the group division gives the group offset.
      if (i == ITER_FIELD_BITS) begin
         y.offset = x.is_max ? (x.size - SIZE_W'(x.loop_size)) : (x.size - x.rem);
      end
      return y;
   endfunction

   assign rdy[DIV_STAGES] = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_item  = st_ff[DIV_STAGES-1];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      item_type prev;
      logic     prev_vld;
      assign rdy[g] = !vld_ff[g] || rdy[g+1];
      if (g == 0) begin : g_first
         assign prev     = in_item;
         assign prev_vld = in_valid;
      end else begin : g_next
         assign prev     = st_ff[g-1];
         assign prev_vld = vld_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            vld_ff[g] <= prev_vld;
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[g]) st_ff[g] <= div_step(prev, g);
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tsls_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer size loop splitter back end
// Applies the saturated case, packs the remainder word and holds the result.
// ----------------------------------------------------------------------------
module tsls_finish (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  tsls_pkg::item_type   in_item,
   output logic                 out_valid,
   input  wire                  out_ready,
   output tsls_pkg::result_type out_res
);
   import tsls_pkg::*;

   logic        vld_ff;
   result_type  res_ff;
   result_type  res_in;
   logic [ITER_FIELD_BITS-1:0] m_e;
   logic [N_BITS-1:0]          n_e;
   logic [SB_W-1:0]            p_e;
   logic [PAR_W-1:0]           rep;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_res   = res_ff;

   always_comb begin
      m_e = in_item.is_max ? MAX_ITER : in_item.m;
      n_e = in_item.is_max ? N_BITS'(in_item.lc - LC_W'(1)) : in_item.n;
      p_e = in_item.is_max ? in_item.sb : SB_W'(in_item.rem);
      rep = PAR_W'(n_e) - PAR_W'(1);
      res_in.group_offset    = in_item.offset;
      res_in.iteration_count = ITER_OUT_W'(m_e);
      res_in.size_overflow   = in_item.ovf;
      case ({n_e != '0, p_e != '0})
         2'b10: begin
            res_in.extend_word = (EXT_W'(rep) << REPEAT_SHIFT) |
                                 (EXT_W'(1) << TOTAL_SHIFT);
            res_in.tail_bytes  = in_item.sb;
         end
         2'b01: begin
            res_in.extend_word = EXT_W'(1) << TOTAL_SHIFT;
            res_in.tail_bytes  = p_e;
         end
         2'b11: begin
            res_in.extend_word = (EXT_W'(rep) << REPEAT_SHIFT) |
                                 (EXT_W'(1) << LOOPIDX_SHIFT) |
                                 (EXT_W'(2) << TOTAL_SHIFT);
            res_in.tail_bytes  = p_e;
         end
         default: begin
            res_in.extend_word = '0;
            res_in.tail_bytes  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) res_ff <= res_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/transfer_size_loop_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer size loop splitter
// Splits a transfer size into full loop groups, whole slices and a byte tail.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the req_ channel carries one transfer size. Each word on the
// rsp_ channel carries its loop descriptor: the group offset, the iteration
// count, the packed remainder word, the tail size and the overflow flag.
// The csr_ port writes the slices-per-loop and slice-size registers; it
// should only be used while no word is in flight.
// From acceptance to the result a word passes three front end stages
// (clamp, loop size multiply, saturation compare), twenty divider stages
// (13 group quotient bits then 7 slice quotient bits, one restoring
// subtract each) and the output register.
// Throughput is one word per cycle. Every stage has its own valid bit and
// takes a new word whenever it is empty or its successor moves, so when the
// receiver stalls the pipeline fills up behind the output register and no
// word is lost or repeated; bubbles are squeezed out.
// Reset empties every stage and sets both registers to one.
// ----------------------------------------------------------------------------
module transfer_size_loop_splitter (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // tdata: transfer_size [52:0], zero padding above
   input  wire  [tsls_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // tdata: group_offset [52:0], iteration_count [65:53],
   // extend_word [127:66], tail_bytes [159:128], size_overflow [160],
   // zero padding above
   output logic [tsls_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire                                 csr_we,
   input  wire  [tsls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tsls_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tsls_pkg::*;

   logic [LC_W-1:0] slices_ff;
   logic [SB_W-1:0] sbytes_ff;

   item_type   prep_item;
   logic       prep_valid;
   logic       prep_ready;
   item_type   div_item;
   logic       div_valid;
   logic       div_ready;
   result_type res;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= LC_W'(1);
         sbytes_ff <= SB_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLICES: slices_ff <= csr_wdata[LC_W-1:0];
            CSR_SBYTES: sbytes_ff <= csr_wdata[SB_W-1:0];
            default: ;
         endcase
      end
   end

   tsls_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_size    (req_tdata[SIZE_W-1:0]),
      .cfg_slices (slices_ff),
      .cfg_sbytes (sbytes_ff),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_item   (prep_item)
   );

   tsls_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_item   (prep_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   tsls_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   // The result struct packs from the low bit up in the documented order.
   assign rsp_tdata = RSP_DATA_W'(res);

   // The pipeline is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   // A saturated size always reports the full iteration count.
   a_ovf_iter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.size_overflow |->
         res.iteration_count == ITER_OUT_W'(MAX_ITER))
      else $error("overflowed size without full iteration count");

   // A tail exists exactly when there is a remainder descriptor.
   a_tail_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((res.tail_bytes != '0) == (res.extend_word != '0)))
      else $error("tail size and remainder word disagree");

   // No full group means no group offset.
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (res.iteration_count == '0) |-> (res.group_offset == '0))
      else $error("group offset without any full group");

endmodule
`default_nettype wire

FILE: test/tb_transfer_size_loop_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer size loop splitter testbench
// Drives transfer sizes through the splitter under several register settings
// and checks each descriptor against the local split model or one typed by hand.
// ----------------------------------------------------------------------------
module tb_transfer_size_loop_splitter;
   import tsls_pkg::*;

   // Index beyond the two registers; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam int                   CYCLE_LIMIT = 2000000;
   localparam int                   DRAIN_CYCLES = 40;
   localparam int                   LONG_HOLD = 200;
   localparam int                   RANDOM_PHASES = 8;
   localparam int                   WORDS_PER_PHASE = 150;

   typedef enum logic {ROW_CSR, ROW_SIZE} row_kind_type;

   // One row of the directed table: either a register write or a size, the
   // latter optionally with its descriptor typed in by hand.
   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          value;
      logic [SIZE_W-1:0]    size;
      bit                   known;
      result_type           descriptor;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // The model's own copy of the two registers.
   logic [LC_W-1:0] slices_reg;
   logic [SB_W-1:0] sbytes_reg;

   result_type     pending_descriptors[$];
   table_row_type  directed_rows[$];
   int             mismatches = 0;
   int             cycle_count = 0;
   bit             calm = 1'b0;        // no idling on either side when set
   bit             long_hold_req = 1'b0;

   transfer_size_loop_splitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Effective register values: zero counts as one, and the slice count is
   // capped so that the repeat field stays inside the remainder word.
   function automatic logic [63:0] eff_slices();
      if (slices_reg == '0) return 64'd1;
      if (slices_reg > SLICES_MAX) return 64'(SLICES_MAX);
      return 64'(slices_reg);
   endfunction

   function automatic logic [63:0] eff_sbytes();
      return (sbytes_reg == '0) ? 64'd1 : 64'(sbytes_reg);
   endfunction

   function automatic logic [63:0] max_transfer();
      return eff_slices() * eff_sbytes() * (64'(MAX_ITER) + 64'd1);
   endfunction

   // The repeat field runs past the top of the word; its upper bit drops off.
   function automatic logic [EXT_W-1:0] pack_remainder(logic [63:0] rep,
                                                       logic [63:0] idx,
                                                       logic [63:0] total);
      return (EXT_W'(rep[PAR_W-1:0]) << REPEAT_SHIFT) |
             (EXT_W'(idx[PAR_W-1:0]) << LOOPIDX_SHIFT) |
             (EXT_W'(total[PAR_W-1:0]) << TOTAL_SHIFT);
   endfunction

   // Splits one size into m full groups, n whole slices and a byte tail p.
   function automatic result_type split_transfer(logic [SIZE_W-1:0] size_in);
      logic [63:0] lc, sb, loop_bytes, limit, size, m, n, p;
      result_type  r;
      lc = eff_slices();
      sb = eff_sbytes();
      loop_bytes = lc * sb;
      limit = max_transfer();
      size = 64'(size_in);
      r = '0;
      if (size > limit) begin
         size = limit;
         r.size_overflow = 1'b1;
      end
      if (size == limit) begin
         // The largest size is encoded as the last group plus a full slice.
         m = 64'(MAX_ITER);
         n = lc - 64'd1;
         p = sb;
      end else begin
         m = size / loop_bytes;
         n = (size - m * loop_bytes) / sb;
         p = size - m * loop_bytes - n * sb;
      end
      if (n == 0 && p == 0) begin
         r.extend_word = '0;
         r.tail_bytes  = '0;
      end else if (p == 0) begin
         r.extend_word = pack_remainder(n - 64'd1, 64'd0, 64'd1);
         r.tail_bytes  = sb[TAIL_W-1:0];
      end else if (n == 0) begin
         r.extend_word = pack_remainder(64'd0, 64'd0, 64'd1);
         r.tail_bytes  = p[TAIL_W-1:0];
      end else begin
         r.extend_word = pack_remainder(n - 64'd1, 64'd1, 64'd2);
         r.tail_bytes  = p[TAIL_W-1:0];
      end
      r.group_offset    = SIZE_W'(sb * lc * m);
      r.iteration_count = m[ITER_OUT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      mismatches++;
   endtask

   // Result side: compare each accepted word with the oldest expectation.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_descriptors.size() == 0) begin
            report_mismatch("unexpected word", 64'(got.iteration_count), 64'd0);
         end else begin
            want = pending_descriptors.pop_front();
            if (got.group_offset != want.group_offset)
               report_mismatch("group_offset", 64'(got.group_offset), 64'(want.group_offset));
            if (got.iteration_count != want.iteration_count)
               report_mismatch("iteration_count", 64'(got.iteration_count),
                               64'(want.iteration_count));
            if (got.extend_word != want.extend_word)
               report_mismatch("extend_word", 64'(got.extend_word), 64'(want.extend_word));
            if (got.tail_bytes != want.tail_bytes)
               report_mismatch("tail_bytes", 64'(got.tail_bytes), 64'(want.tail_bytes));
            if (got.size_overflow != want.size_overflow)
               report_mismatch("size_overflow", 64'(got.size_overflow),
                               64'(want.size_overflow));
         end
      end
   end

   // Receiver: random stall bursts, and one long hold that it counts out
   // itself when the sender asks for it.
   always @(posedge clock) begin
      static int hold_left = 0;
      static int stall_left = 0;
      if (long_hold_req && hold_left == 0) begin
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a stuck handshake must not hang the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("transfer_size_loop_splitter: mismatch");
         $finish;
      end
   end

   // Offers one size and holds it until accepted; the expectation is queued
   // at the accepting edge, with the register values in force at that time.
   task automatic send_size(logic [SIZE_W-1:0] size, bit known, result_type descriptor);
      result_type expected;
      req_tdata  <= REQ_DATA_W'(size);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected = known ? descriptor : split_transfer(size);
      pending_descriptors.insert(pending_descriptors.size(), expected);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every descriptor is back; the extra
   // cycles cover the depth of the pipeline.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_descriptors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes are issued only while the block is idle.
   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
      wait_until_idle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_SLICES) slices_reg = value[LC_W-1:0];
      else if (index == CSR_SBYTES) sbytes_reg = value;
   endtask

   // Picks a size: mostly a well-formed split of the current loop geometry,
   // with the largest size, overflowing sizes and raw 53-bit values mixed in.
   function automatic logic [SIZE_W-1:0] pick_size();
      logic [63:0] lc, sb, m, n, p, limit, span;
      int          choice;
      lc = eff_slices();
      sb = eff_sbytes();
      limit = max_transfer();
      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
         m = (choice < 3) ? 64'($urandom_range(0, 3)) : 64'($urandom_range(0, MAX_ITER));
         n = 64'($urandom_range(0, 32'(lc - 1)));
         p = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(0, 32'(sb - 1)));
         return SIZE_W'(m * lc * sb + n * sb + p);
      end else if (choice == 6) begin
         return SIZE_W'(limit);
      end else if (choice == 7) begin
         return SIZE_W'(limit + 64'($urandom_range(1, 1000)));
      end else if (choice == 8) begin
         return SIZE_W'({$urandom, $urandom});
      end
      span = (3 * lc * sb < 64'hFFFF_FFFF) ? 3 * lc * sb : 64'hFFFF_FFFF;
      return SIZE_W'($urandom_range(0, 32'(span)));
   endfunction

   task automatic add_csr(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
      table_row_type row;
      row = '{ROW_CSR, index, value, '0, 1'b0, '0};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_size(logic [SIZE_W-1:0] size, bit known, result_type descriptor);
      table_row_type row;
      row = '{ROW_SIZE, '0, '0, size, known, descriptor};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   initial begin
      // Fields from the top: overflow, tail, remainder word, groups, offset.
      result_type  zero_desc, max_desc, ovf_desc, five_desc;
      logic [31:0] lc_pick, sb_pick;

      slices_reg = LC_W'(1);
      sbytes_reg = SB_W'(1);

      zero_desc = '0;
      five_desc = '{1'b0, 32'd0, 62'd0, 13'd5, 53'd5};
      // With one one-byte slice per group the largest size is 8192 bytes:
      // the last group plus a single tail slice.
      max_desc  = '{1'b0, 32'd1, 62'(1) << TOTAL_SHIFT, 13'd8191, 53'd8191};
      ovf_desc  = max_desc;
      ovf_desc.size_overflow = 1'b1;

      // Directed table, starting from the reset values of both registers.
      add_size(53'd0, 1'b1, zero_desc);
      add_size(53'd5, 1'b1, five_desc);
      add_size(53'd8191, 1'b0, zero_desc);
      add_size(53'd8192, 1'b1, max_desc);
      add_size(53'd8193, 1'b1, ovf_desc);
      add_size('1, 1'b1, ovf_desc);
      // Four slices of ten bytes per group: all four remainder encodings.
      add_csr(CSR_SLICES, 32'd4);
      add_csr(CSR_SBYTES, 32'd10);
      add_size(53'd10, 1'b0, zero_desc);
      add_size(53'd3, 1'b0, zero_desc);
      add_size(53'd25, 1'b0, zero_desc);
      add_size(53'd40, 1'b0, zero_desc);
      add_size(53'd327679, 1'b0, zero_desc);
      add_size(53'd327680, 1'b0, zero_desc);
      add_size(53'd327681, 1'b0, zero_desc);
      // Zero in both registers is read as one; the unused index is ignored.
      add_csr(CSR_SLICES, 32'd0);
      add_csr(CSR_SBYTES, 32'd0);
      add_csr(CSR_UNUSED, 32'h55);
      add_size(53'd8192, 1'b1, max_desc);
      add_size(53'd9000, 1'b1, ovf_desc);
      // Slice count above the cap, with the widest slice size.
      add_csr(CSR_SLICES, 32'hFF);
      add_csr(CSR_SBYTES, 32'hFFFF_FFFF);
      add_size('1, 1'b0, zero_desc);
      add_size(53'(64'd128 * 64'hFFFF_FFFF * 64'd8192), 1'b0, zero_desc);
      add_size(53'(64'd128 * 64'hFFFF_FFFF * 64'd8192 - 1), 1'b0, zero_desc);
      add_size(53'h1A_5A5A_5A5A_5A5A, 1'b0, zero_desc);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_register(directed_rows[i].index, directed_rows[i].value);
         else
            send_size(directed_rows[i].size, directed_rows[i].known,
                      directed_rows[i].descriptor);
      end

      // Random part: one register setting per phase, extremes first.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin lc_pick = 32'd1;   sb_pick = 32'd1;          end
            1: begin lc_pick = 32'd128; sb_pick = 32'hFFFF_FFFF;  end
            2: begin lc_pick = 32'd3;   sb_pick = 32'd1000;       end
            3: begin lc_pick = 32'd200; sb_pick = 32'd7;          end
            4: begin lc_pick = 32'd1;   sb_pick = 32'hFFFF_FFFF;  end
            5: begin lc_pick = 32'd128; sb_pick = 32'd1;          end
            default: begin
               lc_pick = 32'($urandom_range(0, 255));
               sb_pick = $urandom;
            end
         endcase
         write_register(CSR_SLICES, lc_pick);
         write_register(CSR_SBYTES, sb_pick);
         // The last phase runs with no idling on either side.
         calm = (ph == RANDOM_PHASES - 1);
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            // Once, the receiver holds off for a long stretch while the
            // sender keeps offering, so the pipeline fills and backs up.
            if (ph == 2 && k == 10) long_hold_req = 1'b1;
            if (ph == 2 && k == 11) long_hold_req = 1'b0;
            send_size(pick_size(), 1'b0, zero_desc);
         end
      end

      wait_until_idle();

      if (mismatches == 0) begin
         $display("transfer_size_loop_splitter: match");
      end else begin
         $display("transfer_size_loop_splitter: mismatch");
      end
      $finish;
   end

endmodule
